FILE: rtl/button_debounce_auto_repeat_assert.svh
// Assertion macros shared by the button debounce RTL.
`ifndef BUTTON_DEBOUNCE_AUTO_REPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTO_REPEAT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BDAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define BDAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/bdar_pkg.sv
// Package with types and constants for the button debounce block.
package bdar_pkg;

    localparam int FILTER_DEPTH_DEFAULT = 4;

    localparam int TICKS_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_AUTO_REPEAT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESSED_LEVEL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_TICKS  = 2'd2;

    localparam logic [TICKS_W-1:0] REPEAT_TICKS_RESET = 16'd100;

    typedef struct packed {
        logic               auto_repeat;
        logic               pressed_level;
        logic [TICKS_W-1:0] repeat_ticks;
    } cfg_t;

endpackage

FILE: rtl/bdar_if.sv
// Valid/ready stream interfaces for pin samples and debounced results.
interface bdar_sample_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink (input valid, input pin_level, output ready);
endinterface

interface bdar_result_if;
    logic valid;
    logic ready;
    logic press_event;
    logic stable_level;

    modport source (output valid, output press_event, output stable_level, input ready);
    modport sink (input valid, input press_event, input stable_level, output ready);
endinterface

FILE: rtl/bdar_core.sv
// Debounce window, committed level and auto-repeat counter.
`include "button_debounce_auto_repeat_assert.svh"

module bdar_core #(
    parameter int FILTER_DEPTH = bdar_pkg::FILTER_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            pin_level,
    input  bdar_pkg::cfg_t  cfg,
    output logic            press_event,
    output logic            stable_level
);

    localparam int WIN_W = FILTER_DEPTH - 1;
    localparam logic [bdar_pkg::TICKS_W-1:0] COUNT_ONE = {{(bdar_pkg::TICKS_W-1){1'b0}}, 1'b1};

    logic [WIN_W-1:0]            window_reg, window_next;
    logic                        committed_reg, committed_next;
    logic [bdar_pkg::TICKS_W-1:0] count_reg, count_next;
    logic                        expired_reg, expired_next;
    logic                        agree;
    logic                        released;
    logic                        expired_tmp;

    // Compute the state after one sample
    always_comb
    begin
        window_next    = {window_reg[WIN_W-2:0], pin_level};
        agree          = (window_next == {WIN_W{1'b0}}) || (window_next == {WIN_W{1'b1}});
        released       = ~cfg.pressed_level;
        committed_next = committed_reg;
        count_next     = count_reg;
        expired_next   = expired_reg;
        expired_tmp    = expired_reg;
        press_event    = 1'b0;
        if (agree)
        begin
            if (committed_reg != pin_level)
            begin
                committed_next = pin_level;
                if (pin_level == cfg.pressed_level)
                begin
                    press_event = 1'b1;
                    if (cfg.auto_repeat)
                    begin
                        count_next   = cfg.repeat_ticks;
                        expired_next = 1'b0;
                    end
                end
            end
            else if (cfg.auto_repeat)
            begin
                // Count down; flag expiry when the count hits zero
                if (count_reg != '0)
                begin
                    count_next = count_reg - COUNT_ONE;
                    if (count_reg == COUNT_ONE)
                    begin
                        expired_tmp = 1'b1;
                    end
                end
                expired_next = expired_tmp;
                if (expired_tmp)
                begin
                    committed_next = released;
                end
            end
        end
        stable_level = committed_next;
    end

    // Advance state on each processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= {WIN_W{1'b1}};
            committed_reg <= 1'b1;
            count_reg     <= '0;
            expired_reg   <= 1'b0;
        end
        else if (step)
        begin
            window_reg    <= window_next;
            committed_reg <= committed_next;
            count_reg     <= count_next;
            expired_reg   <= expired_next;
        end
    end

    `BDAR_ASSERT_IMPL(a_event_press, clk, rst_n, step && press_event, stable_level == cfg.pressed_level)
    `BDAR_ASSERT_NEXT(a_tap_freezes_count, clk, rst_n, !cfg.auto_repeat, $stable(count_reg))
    `BDAR_ASSERT_IMPL(a_expiry_from_step, clk, rst_n, $rose(expired_reg), $past(step && cfg.auto_repeat))

endmodule

FILE: rtl/button_debounce_auto_repeat.sv
// A transferred sample passes the input register, core logic and result register to the output.
// Throughput: one sample per cycle while the result side is not stalled.
// The input keeps transferring while a result waits, until both registers are full.
// Reset (rst_n low, asynchronous) empties both registers, sets the window and level
// to released, clears the repeat counter and expiry flag, and loads register defaults.
`include "button_debounce_auto_repeat_assert.svh"

module button_debounce_auto_repeat #(
    parameter int FILTER_DEPTH = bdar_pkg::FILTER_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bdar_sample_if.sink                      samples,
    bdar_result_if.source                    results,
    input  logic                             cfg_wr_en,
    input  logic [bdar_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bdar_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    bdar_pkg::cfg_t cfg_reg;
    logic           in_valid_reg;
    logic           in_pin_reg;
    logic           out_valid_reg;
    logic           out_event_reg;
    logic           out_level_reg;
    logic           advance;
    logic           core_event;
    logic           core_level;

    // Move the input stage on when the result register is free or draining
    assign advance       = !out_valid_reg || results.ready;
    assign samples.ready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_repeat   <= 1'b0;
            cfg_reg.pressed_level <= 1'b0;
            cfg_reg.repeat_ticks  <= bdar_pkg::REPEAT_TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bdar_pkg::REG_AUTO_REPEAT:   cfg_reg.auto_repeat   <= cfg_wr_data[0];
                bdar_pkg::REG_PRESSED_LEVEL: cfg_reg.pressed_level <= cfg_wr_data[0];
                bdar_pkg::REG_REPEAT_TICKS:
                    cfg_reg.repeat_ticks <= cfg_wr_data[bdar_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the transferred sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_pin_reg <= samples.pin_level;
        end
    end

    bdar_core #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_valid_reg && advance),
        .pin_level    (in_pin_reg),
        .cfg          (cfg_reg),
        .press_event  (core_event),
        .stable_level (core_level)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_event_reg <= core_event;
            out_level_reg <= core_level;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.press_event  = out_event_reg;
    assign results.stable_level = out_level_reg;

    `BDAR_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    `BDAR_ASSERT_NEXT(a_in_capture, clk, rst_n, samples.valid && samples.ready, in_valid_reg)
    `BDAR_ASSERT_NEXT(a_out_hold, clk, rst_n, results.valid && !results.ready, results.valid)

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the button debouncer with auto-repeat.
`timescale 1ns / 100ps

module tb;

    localparam int WIN_W      = bdar_pkg::FILTER_DEPTH_DEFAULT - 1;
    localparam int IDLE_LIMIT = 3000;
    localparam int SQUEEZE_AT = 500;
    localparam int SQUEEZE_LEN = 400;

    typedef struct packed {
        logic press_event;
        logic stable_level;
    } tick_result_t;

    // Tracks the debouncer state and holds the results still owed by the block.
    class debounce_tracker;
        logic                         auto_repeat;
        logic                         pressed_level;
        logic [bdar_pkg::TICKS_W-1:0] repeat_ticks;
        logic [WIN_W-1:0]             window;
        logic                         committed;
        logic [bdar_pkg::TICKS_W-1:0] count;
        logic                         expired;
        tick_result_t                 owed_ticks[$];
        int                           failures;

        function new();
            auto_repeat   = 1'b0;
            pressed_level = 1'b0;
            repeat_ticks  = bdar_pkg::REPEAT_TICKS_RESET;
            window        = '1;
            committed     = 1'b1;
            count         = '0;
            expired       = 1'b0;
            failures      = 0;
        endfunction

        function void set_register(logic [bdar_pkg::CFG_INDEX_W-1:0] index,
                                   logic [bdar_pkg::CFG_DATA_W-1:0] data);
            case (index)
                bdar_pkg::REG_AUTO_REPEAT:   auto_repeat = data[0];
                bdar_pkg::REG_PRESSED_LEVEL: pressed_level = data[0];
                bdar_pkg::REG_REPEAT_TICKS:  repeat_ticks = data[bdar_pkg::TICKS_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance one tick and queue the result it owes.
        function void note_sample(logic pin);
            tick_result_t res;
            logic         stable;
            res.press_event = 1'b0;
            window = {window[WIN_W-2:0], pin};
            stable = (window == '0) || (window == '1);
            if (stable) begin
                if (committed != pin) begin
                    committed = pin;
                    if (pin == pressed_level) begin
                        res.press_event = 1'b1;
                        if (auto_repeat) begin
                            count   = repeat_ticks;
                            expired = 1'b0;
                        end
                    end
                end
                else if (auto_repeat) begin
                    if (count != '0) begin
                        count = count - 1'b1;
                        if (count == '0)
                            expired = 1'b1;
                    end
                    if (expired)
                        committed = ~pressed_level;
                end
            end
            res.stable_level = committed;
            owed_ticks.push_back(res);
        endfunction

        function void check_result(logic press_event, logic stable_level);
            tick_result_t want;
            if (owed_ticks.size() == 0) begin
                $display("%0t: unexpected result press_event=%b stable_level=%b",
                         $time, press_event, stable_level);
                failures++;
                return;
            end
            want = owed_ticks.pop_front();
            if (press_event !== want.press_event) begin
                $display("%0t: press_event expected %b actual %b",
                         $time, want.press_event, press_event);
                failures++;
            end
            if (stable_level !== want.stable_level) begin
                $display("%0t: stable_level expected %b actual %b",
                         $time, want.stable_level, stable_level);
                failures++;
            end
        endfunction

        function int pending();
            return owed_ticks.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [bdar_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [bdar_pkg::CFG_DATA_W-1:0]  cfg_wr_data;

    bdar_sample_if samples_bus ();
    bdar_result_if results_bus ();

    debounce_tracker tracker = new();

    int unsigned results_seen;
    int unsigned idle_cycles;
    bit          steady_phase;

    button_debounce_auto_repeat dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_bus),
        .results     (results_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones; none in steady phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    // Offer one pin sample and hold it until the transfer.
    task automatic push_sample(input logic pin);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            samples_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_bus.valid     <= 1'b1;
        samples_bus.pin_level <= pin;
        do
            @(posedge clk);
        while (!samples_bus.ready);
        tracker.note_sample(pin);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        samples_bus.valid <= 1'b0;
    endtask

    // Wait for every owed result, then let the pipeline drain.
    task automatic drain();
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bdar_pkg::CFG_INDEX_W-1:0] index,
                             input logic [bdar_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= data;
        @(posedge clk);
        tracker.set_register(index, data);
    endtask

    task automatic configure(input logic hold, input logic pressed,
                             input logic [bdar_pkg::TICKS_W-1:0] ticks);
        write_reg(bdar_pkg::REG_AUTO_REPEAT, bdar_pkg::CFG_DATA_W'(hold));
        write_reg(bdar_pkg::REG_PRESSED_LEVEL, bdar_pkg::CFG_DATA_W'(pressed));
        write_reg(bdar_pkg::REG_REPEAT_TICKS, ticks);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly clean presses and releases of random length, with some bounce.
    task automatic run_phase(input logic hold, input logic pressed,
                             input logic [bdar_pkg::TICKS_W-1:0] ticks, input int n_items,
                             input bit steady);
        int   sent;
        int   r;
        int   run_len;
        logic level;
        steady_phase = steady;
        configure(hold, pressed, ticks);
        sent = 0;
        while (sent < n_items)
        begin
            r     = $urandom_range(0, 99);
            level = 1'($urandom_range(0, 1));
            if (r < 50)
                run_len = $urandom_range(3, 10);
            else if (r < 75)
                run_len = $urandom_range(10, 30);
            else
                run_len = $urandom_range(1, 2);
            repeat (run_len) push_sample(level);
            sent += run_len;
        end
        drop_valid();
        drain();
    endtask

    // Check every result transfer against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && results_bus.valid && results_bus.ready)
        begin
            tracker.check_result(results_bus.press_event, results_bus.stable_level);
            results_seen <= results_seen + 1;
        end
    end

    // End the run when nothing has transferred for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples_bus.valid && samples_bus.ready) ||
                (results_bus.valid && results_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("button_debounce_auto_repeat: mismatch");
                $finish;
            end
        end
    end

    // Stall the result side at random, with one long hold-off to back up the input.
    initial
    begin
        int stall_left;
        bit squeezed;
        stall_left = 0;
        squeezed   = 1'b0;
        results_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!squeezed && results_seen >= SQUEEZE_AT)
            begin
                squeezed   = 1'b1;
                stall_left = SQUEEZE_LEN;
            end
            if (stall_left > 0)
            begin
                results_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                results_bus.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        logic [17:0] opening;
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = '0;
        cfg_wr_data           = '0;
        samples_bus.valid     = 1'b0;
        samples_bus.pin_level = 1'b0;
        results_seen          = 0;
        idle_cycles           = 0;
        steady_phase          = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Press, expire and repeat, bounce, release before expiry, press again.
        steady_phase = 1'b1;
        configure(1'b1, 1'b0, 16'd2);
        opening = 18'b000000_1010_11111_000;
        for (int i = 17; i >= 0; i--)
            push_sample(opening[i]);
        drop_valid();
        drain();

        run_phase(1'b0, 1'b0, bdar_pkg::REPEAT_TICKS_RESET, 190, 1'b0);
        run_phase(1'b1, 1'b0, 16'd0, 190, 1'b0);
        run_phase(1'b1, 1'b1, 16'd1, 190, 1'b0);
        run_phase(1'b1, 1'b0, 16'd3, 190, 1'b1);
        run_phase(1'b0, 1'b1, 16'hFFFF, 150, 1'b0);
        run_phase(1'b1, 1'b1, 16'hFFFF, 150, 1'b0);
        run_phase(1'b1, 1'b0, 16'($urandom_range(0, 65535)), 150, 1'b0);
        run_phase(1'b1, 1'b1, 16'd5, 190, 1'b0);
        run_phase(1'b1, 1'b0, 16'($urandom_range(1, 12)), 190, 1'b1);
        run_phase(1'b0, 1'b0, 16'd0, 150, 1'b0);
        run_phase(1'b1, 1'b1, 16'($urandom_range(1, 20)), 150, 1'b0);

        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("button_debounce_auto_repeat: match");
        else
            $display("button_debounce_auto_repeat: mismatch");
        $finish;
    end
endmodule
